// ===== design/lnts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lnts_pkg
// Shared widths, limits and rounding helper for the ln series pipeline.
// ----------------------------------------------------------------------------
package lnts_pkg;

    localparam int X_W        = 18;   // x_value width, unsigned Q2.16
    localparam int OUT_W      = 20;   // ln_value width, signed Q16
    localparam int TC_W       = 6;    // term_count register width
    localparam int RECIP_BITS = 30;   // fraction bits of the 1/n constants
    localparam int POW_W      = 32;   // clamped power width
    localparam int TPROD_W    = 64;   // power times reciprocal product
    localparam int ACC_W      = 40;   // series accumulator width
    localparam int IN_DATA_W  = 24;   // input tdata, whole bytes
    localparam int OUT_DATA_W = 24;   // output tdata, whole bytes

    localparam logic [TC_W-1:0] TERM_COUNT_RESET = TC_W'(16);

    localparam logic signed [ACC_W-1:0] OUT_LOW  = -ACC_W'(524288);
    localparam logic signed [ACC_W-1:0] OUT_HIGH = ACC_W'(65536);

    typedef logic signed [POW_W-1:0]   pow_t;
    typedef logic signed [TPROD_W-1:0] tprod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // round a power-times-reciprocal product by 2^30, half away from zero
    function automatic acc_t round_term(input tprod_t v);
        tprod_t half;
        tprod_t sum;
        half = tprod_t'(1) <<< (RECIP_BITS - 1);
        sum  = v + half - tprod_t'(v[TPROD_W-1]);
        return ACC_W'(sum >>> RECIP_BITS);
    endfunction

endpackage
`default_nettype wire

// ===== design/ln_taylor_series.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ln_taylor_series
// Natural log by a truncated Taylor series about 1, one stage per term.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output is not stalled, one term multiplier per stage
// and one power multiplier per stage but the last; a stall on the output freezes every stage,
// nothing is lost or repeated; reset: pipeline and output valids cleared, term_count back to 16
module ln_taylor_series #(
    parameter int TERMS_MAX = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // configuration: term_count
    input  wire                                 cfg_we,
    input  wire [lnts_pkg::TC_W-1:0]            cfg_wdata,
    // input items
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire [lnts_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [17:0] x_value, rest zero
    input  wire                                 s_axis_tlast,  // last_in
    // result items
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [lnts_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [19:0] ln_value, rest zero
    output logic                                m_axis_tlast   // last_out
);
    import lnts_pkg::*;

    // width of d = x - 1.0
    localparam int DW  = (FRAC_BITS + 2 > X_W + 1) ? FRAC_BITS + 2 : X_W + 1;
    localparam int PPW = POW_W + DW;      // power product width
    localparam int PRW = PPW + 1;         // rounded power sum width

    localparam logic signed [DW-1:0]  ONE_D    = DW'(1) <<< FRAC_BITS;
    localparam logic signed [PRW-1:0] HALF_P   = PRW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PRW-1:0] POW_HI   = PRW'(64'sd2147483647);
    localparam logic signed [PRW-1:0] POW_LO   = -PRW'(64'sd2147483647);

    // configuration register
    logic [TC_W-1:0] term_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TERM_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            term_count_reg <= cfg_wdata;
        end
    end

    // global advance: the output register is free or being drained
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // pipeline storage
    logic               valid_reg [1:TERMS_MAX+1];
    logic               last_reg  [1:TERMS_MAX+1];
    logic signed [DW-1:0] d_reg   [1:TERMS_MAX-1];
    pow_t               p_reg     [1:TERMS_MAX];
    tprod_t             tp_reg    [2:TERMS_MAX+1];
    acc_t               acc_reg   [2:TERMS_MAX+1];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= TERMS_MAX + 1; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[1] <= s_axis_tvalid;
            for (int i = 2; i <= TERMS_MAX + 1; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // entry stage: d = x - 1.0, first power is d
    logic signed [DW-1:0] d_in;
    assign d_in = $signed({{(DW-X_W){1'b0}}, s_axis_tdata[X_W-1:0]}) - ONE_D;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg[1] <= s_axis_tlast;
            p_reg[1]    <= POW_W'(d_in);
            if (TERMS_MAX > 1)
            begin
                d_reg[1] <= d_in;
            end
        end
    end

    // one stage per term
    for (genvar k = 1; k <= TERMS_MAX; k++)
    begin : g_stage
        localparam logic signed [POW_W-1:0] RECIP =
            POW_W'(((64'sd1 <<< RECIP_BITS) + k / 2) / k);

        // next power p(k+1) = clamp(rnd(p(k) * d))
        if (k < TERMS_MAX)
        begin : g_pow
            logic signed [PPW-1:0] pprod;
            logic signed [PRW-1:0] pround;
            pow_t                  pnext;

            always_comb
            begin
                pprod  = p_reg[k] * d_reg[k];
                pround = (PRW'(pprod) + HALF_P - $signed(PRW'(pprod[PPW-1]))) >>> FRAC_BITS;
                if (pround > POW_HI)
                begin
                    pnext = POW_W'(POW_HI);
                end
                else if (pround < POW_LO)
                begin
                    pnext = POW_W'(POW_LO);
                end
                else
                begin
                    pnext = POW_W'(pround);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p_reg[k+1] <= pnext;
                end
            end

            // d travels beside the powers while a later stage still needs it
            if (k + 1 < TERMS_MAX)
            begin : g_d
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        d_reg[k+1] <= d_reg[k];
                    end
                end
            end
        end

        // term product p(k) * 1/k, and past the first stage the add of the previous term
        if (k == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tp_reg[k+1]   <= tprod_t'(p_reg[k]) * tprod_t'(RECIP);
                    acc_reg[k+1]  <= '0;
                    last_reg[k+1] <= last_reg[k];
                end
            end
        end
        else
        begin : g_add
            acc_t term;
            acc_t acc_next;

            always_comb
            begin
                term = round_term(tp_reg[k]);
                if ({1'b0, term_count_reg} >= (TC_W+1)'(k - 1))
                begin
                    acc_next = (((k - 1) % 2) == 1) ? acc_reg[k] + term
                                                    : acc_reg[k] - term;
                end
                else
                begin
                    acc_next = acc_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tp_reg[k+1]   <= tprod_t'(p_reg[k]) * tprod_t'(RECIP);
                    acc_reg[k+1]  <= acc_next;
                    last_reg[k+1] <= last_reg[k];
                end
            end
        end
    end

    // last term, saturation and output register
    acc_t                    fin_term;
    acc_t                    fin_acc;
    logic signed [OUT_W-1:0] ln_next;
    logic signed [OUT_W-1:0] ln_reg;
    logic                    last_out_reg;
    logic                    out_valid_reg;

    always_comb
    begin
        fin_term = round_term(tp_reg[TERMS_MAX+1]);
        if ({1'b0, term_count_reg} >= (TC_W+1)'(TERMS_MAX))
        begin
            fin_acc = ((TERMS_MAX % 2) == 1) ? acc_reg[TERMS_MAX+1] + fin_term
                                             : acc_reg[TERMS_MAX+1] - fin_term;
        end
        else
        begin
            fin_acc = acc_reg[TERMS_MAX+1];
        end

        if (fin_acc > OUT_HIGH)
        begin
            ln_next = OUT_W'(OUT_HIGH);
        end
        else if (fin_acc < OUT_LOW)
        begin
            ln_next = OUT_W'(OUT_LOW);
        end
        else
        begin
            ln_next = OUT_W'(fin_acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[TERMS_MAX+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ln_reg       <= ln_next;
            last_out_reg <= last_reg[TERMS_MAX+1];
        end
    end

    // output drive
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_W){1'b0}}, ln_reg};
    assign m_axis_tlast  = last_out_reg;

endmodule
`default_nettype wire
